>>> rtl/trmv_pkg.sv
// trmv_pkg: shared types and constants of the triangular matrix-vector multiplier
// no dependencies; imported by trmv_acc and triangular_matrix_vector_multiply
package trmv_pkg;

    // request function codes
    localparam logic [1:0] FUNC_MAT = 2'd0;
    localparam logic [1:0] FUNC_VEC = 2'd1;
    localparam logic [1:0] FUNC_RUN = 2'd2;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_UPPER     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TRANSPOSE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_UNIT_DIAG = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SCALE     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SIZE      = 3'd4;

    // fixed point constants, signed Q16.16
    localparam logic signed [31:0] Q_ONE      = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX      = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic [4:0]         SIZE_RESET = 5'd16;

    // accumulator holds up to sixteen Q32.32 products exactly
    localparam int ACC_W = 68;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_TAKE,
        ST_SCALE,
        ST_OUT,
        ST_COPY
    } t_state;

    // accumulator control from the sequencer
    typedef struct packed {
        logic clr;
        logic add;
        logic take;
    } t_acc_ctrl;

endpackage

>>> rtl/trmv_mul.sv
// trmv_mul: shared signed 32x32 multiplier with registered product
// no dependencies; used for both the dot products and the alpha scaling
module trmv_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    // one product per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/trmv_acc.sv
// trmv_acc: wide product accumulator with floor shift and 32-bit saturation
// depends on trmv_pkg for the control struct and Q16.16 limits
module trmv_acc
    import trmv_pkg::*;
(
    input  logic               i_clk,
    input  t_acc_ctrl          i_ctrl,
    input  logic signed [63:0] i_prod,
    output logic signed [31:0] o_sum,
    output logic               o_sat
);

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-17:0] w_sh;
    logic                     w_ovf;
    logic signed [31:0]       w_sum;
    logic signed [31:0]       r_sum;
    logic                     r_sat;

    // exact running sum
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clr) begin
            n_acc = '0;
        end else if (i_ctrl.add) begin
            n_acc = r_acc + {{(ACC_W-64){i_prod[63]}}, i_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // shift right by 16 toward minus infinity, then clip to 32 bits
    assign w_sh  = r_acc[ACC_W-1:16];
    assign w_ovf = !((&w_sh[ACC_W-17:31]) || !(|w_sh[ACC_W-17:31]));
    assign w_sum = w_ovf ? (w_sh[ACC_W-17] ? Q_MIN : Q_MAX) : w_sh[31:0];

    // capture the row sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_sum <= w_sum;
            r_sat <= w_ovf;
        end
    end

    assign o_sum = r_sum;
    assign o_sat = r_sat;

endmodule

>>> rtl/triangular_matrix_vector_multiply.sv
// Triangular matrix-vector multiply x' = alpha * op(T) * x in signed Q16.16.
// Load requests (matrix or vector entry) are taken one per cycle while busy is low
// and keep busy low. A run request of nonzero size raises busy: each of the n rows
// streams its products through the one shared 32x32 multiplier, then drains,
// saturates, is scaled by alpha on the same multiplier and emitted; a final pass
// writes the results back into the vector store. Each result is shown for one
// cycle under o_strobe, in index order, with o_last on the final one; the receiver
// cannot stall, so it must take every strobed result. Entries read by a run must
// have been written since reset. Configuration must be written while busy is low; the block does not enforce it.
module triangular_matrix_vector_multiply
    import trmv_pkg::*;
#(
    parameter int MAX_N = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_col,
    input  logic signed [31:0] i_value,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // results
    output logic               o_strobe,
    output logic [3:0]         o_index,
    output logic signed [31:0] o_result,
    output logic               o_saturated,
    output logic               o_last
);

    localparam int LIMIT  = (MAX_N < 16) ? MAX_N : 16;
    localparam int CW     = $clog2(LIMIT);
    localparam int VW     = $clog2(MAX_N);
    localparam int MDEPTH = MAX_N * MAX_N;
    localparam int MW     = $clog2(MDEPTH);

    // configuration registers
    logic               r_upper;
    logic               r_transpose;
    logic               r_unit_diag;
    logic signed [31:0] r_scale;
    logic [4:0]         r_size;

    // sequencer
    t_state             r_state, n_state;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_nlast, n_nlast;
    logic               w_accept;

    // product pipeline tags
    logic               r_v1, r_v2;
    logic               r_last1, r_last2;
    logic               r_zero1, r_unit1;

    // stores
    logic signed [31:0] r_mat [MDEPTH];
    logic signed [31:0] r_vec [MAX_N];
    logic signed [31:0] r_res [LIMIT];
    logic signed [31:0] r_mdat;
    logic signed [31:0] r_vdat;

    // matrix addressing for the current term
    logic [CW-1:0]      w_r, w_c;
    logic               w_in_tri;
    logic               w_diag;
    logic [MW-1:0]      w_mraddr;
    logic               w_mwe;
    logic [MW-1:0]      w_mwaddr;
    logic               w_vwe;
    logic [VW-1:0]      w_vwaddr;
    logic signed [31:0] w_vwdata;

    // shared arithmetic
    logic               w_mul_en;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    t_acc_ctrl          w_acc_ctrl;
    logic signed [31:0] w_rowsum;
    logic               w_rowsat;
    logic signed [47:0] w_q;
    logic               w_ovf;
    logic signed [31:0] w_out;

    // output registers
    logic               r_strobe;
    logic [3:0]         r_index;
    logic signed [31:0] r_result;
    logic               r_saturated;
    logic               r_last;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= 1'b0;
            r_transpose <= 1'b0;
            r_unit_diag <= 1'b0;
            r_scale     <= Q_ONE;
            r_size      <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UPPER:     r_upper     <= i_cfg_data[0];
                CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                CFG_UNIT_DIAG: r_unit_diag <= i_cfg_data[0];
                CFG_SCALE:     r_scale     <= i_cfg_data;
                CFG_SIZE:      r_size      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // triangle membership of term (i, j)
    assign w_r      = r_transpose ? r_j : r_i;
    assign w_c      = r_transpose ? r_i : r_j;
    assign w_in_tri = r_upper ? (w_r <= w_c) : (w_r >= w_c);
    assign w_diag   = (w_r == w_c);
    assign w_mraddr = MW'(int'(w_r) * MAX_N + int'(w_c));

    // load request decode
    assign w_mwe    = w_accept && (i_func == FUNC_MAT)
                      && (int'(i_row) < MAX_N) && (int'(i_col) < MAX_N);
    assign w_mwaddr = MW'(int'(i_row) * MAX_N + int'(i_col));

    // vector store write: load request or result write-back
    always_comb begin
        w_vwe    = w_accept && (i_func == FUNC_VEC) && (int'(i_row) < MAX_N);
        w_vwaddr = VW'(i_row);
        w_vwdata = i_value;
        if (r_state == ST_COPY) begin
            w_vwe    = 1'b1;
            w_vwaddr = VW'(r_i);
            w_vwdata = r_res[r_i];
        end
    end

    // matrix memory
    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_mat[w_mwaddr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mdat <= r_mat[w_mraddr];
    end

    // vector memory
    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vec[w_vwaddr] <= w_vwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vdat <= r_vec[VW'(r_j)];
    end

    // sequencer next state
    always_comb begin
        int v_n;
        v_n     = (int'(r_size) > LIMIT) ? LIMIT : int'(r_size);
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_nlast = r_nlast;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_func == FUNC_RUN) && (v_n != 0)) begin
                    n_state = ST_MAC;
                    n_i     = '0;
                    n_j     = '0;
                    n_nlast = CW'(v_n - 1);
                end
            end
            ST_MAC: begin
                n_j = r_j + 1'b1;
                if (r_j == r_nlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_v2 && r_last2) begin
                    n_state = ST_TAKE;
                end
            end
            ST_TAKE: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_j = '0;
                if (r_i == r_nlast) begin
                    n_state = ST_COPY;
                    n_i     = '0;
                end else begin
                    n_state = ST_MAC;
                    n_i     = r_i + 1'b1;
                end
            end
            ST_COPY: begin
                n_i = r_i + 1'b1;
                if (r_i == r_nlast) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_nlast <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_nlast <= n_nlast;
            r_v1    <= (r_state == ST_MAC);
            r_v2    <= r_v1;
        end
    end

    // term tags travel beside the memory reads
    always_ff @(posedge i_clk) begin
        r_last1 <= (r_j == r_nlast);
        r_zero1 <= !w_in_tri;
        r_unit1 <= w_diag && r_unit_diag;
        r_last2 <= r_last1;
    end

    // multiplier operands: matrix term times vector entry, or row sum times alpha
    always_comb begin
        w_mul_en = r_v1 || (r_state == ST_SCALE);
        if (r_state == ST_SCALE) begin
            w_mul_a = w_rowsum;
            w_mul_b = r_scale;
        end else begin
            w_mul_a = r_zero1 ? '0 : (r_unit1 ? Q_ONE : r_mdat);
            w_mul_b = r_vdat;
        end
    end

    trmv_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_acc_ctrl.clr  = (r_state == ST_IDLE) || (r_state == ST_TAKE);
    assign w_acc_ctrl.add  = r_v2;
    assign w_acc_ctrl.take = (r_state == ST_TAKE);

    trmv_acc u_acc (
        .i_clk  (i_clk),
        .i_ctrl (w_acc_ctrl),
        .i_prod (w_prod),
        .o_sum  (w_rowsum),
        .o_sat  (w_rowsat)
    );

    // scaled result: floor shift by 16, clip to 32 bits
    assign w_q   = w_prod[63:16];
    assign w_ovf = !((&w_q[47:31]) || !(|w_q[47:31]));
    assign w_out = w_ovf ? (w_q[47] ? Q_MIN : Q_MAX) : w_q[31:0];

    // result buffer, copied to the vector store after the last row
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_res[r_i] <= w_out;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_OUT);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_index     <= 4'(r_i);
            r_result    <= w_out;
            r_saturated <= w_ovf || w_rowsat;
            r_last      <= (r_i == r_nlast);
        end
    end

    assign o_strobe    = r_strobe;
    assign o_index     = r_index;
    assign o_result    = r_result;
    assign o_saturated = r_saturated;
    assign o_last      = r_last;

    // a result only follows the output step of the sequencer
    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_OUT)
        else $error("result strobe without output step");

    // results appear only while a run holds busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // the final result is never followed at once by another
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result after final element");

    // a run of nonzero size raises busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_RUN && r_size != 5'd0) |=> busy)
        else $error("run request did not start");

    // products reach the accumulator only while a row is streaming
    a_acc_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == ST_MAC || r_state == ST_DRAIN))
        else $error("product arrived outside row accumulation");

    // saturation flag is captured only when the row sum is ready
    a_sat_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAKE) |-> !r_v1 && !r_v2)
        else $error("row sum taken with products in flight");

endmodule

>>> verif/tb_triangular_matrix_vector_multiply.sv
// tb_triangular_matrix_vector_multiply: self-checking bench for the triangular matrix-vector multiplier
// drives load and run requests, predicts x' = alpha * op(T) * x per run and checks every result
// depends on trmv_pkg and triangular_matrix_vector_multiply
module tb_triangular_matrix_vector_multiply
    import trmv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N          = 16;
    localparam int ITEM_COUNT     = 100;
    localparam int SETTLE_CYCLES  = MAX_N * MAX_N + 6 * MAX_N + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 40;

    // codes the block has no use for
    localparam logic [1:0]        FUNC_SPARE   = 2'd3;
    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd5;

    typedef struct {
        logic [1:0]         func;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_trmv_req;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] result;
        logic               saturated;
        logic               last;
    } t_product_elem;

    // block ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [1:0]         i_func      = FUNC_MAT;
    logic [3:0]         i_row       = 4'd0;
    logic [3:0]         i_col       = 4'd0;
    logic signed [31:0] i_value     = 32'sd0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index = CFG_UPPER;
    logic [31:0]        i_cfg_data  = 32'd0;
    logic               o_strobe;
    logic [3:0]         o_index;
    logic signed [31:0] o_result;
    logic               o_saturated;
    logic               o_last;

    // requests waiting for the driver, results waiting for the block
    t_trmv_req     requests[$];
    t_product_elem product_elems[$];

    // predicted block state
    logic               cfg_upper = 1'b0;
    logic               cfg_trans = 1'b0;
    logic               cfg_unit  = 1'b0;
    logic signed [31:0] cfg_scale = Q_ONE;
    logic [4:0]         cfg_size  = SIZE_RESET;
    logic signed [31:0] mat_mem [0:MAX_N-1][0:MAX_N-1];
    logic signed [31:0] vec_mem [0:MAX_N-1];

    // stimulus side bookkeeping: which store entries hold data
    bit mat_set [0:MAX_N-1][0:MAX_N-1];
    bit vec_set [0:MAX_N-1];
    bit gen_upper;
    int gen_n;
    int stim_items;

    int mismatches;
    int quiet_cycles;
    bit req_taken;
    bit presenting;
    bit calm;
    int gap;

    triangular_matrix_vector_multiply #(
        .MAX_N(MAX_N)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_index    (o_index),
        .o_result   (o_result),
        .o_saturated(o_saturated),
        .o_last     (o_last)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // saturate to 32 bits, flag in the top bit
    function automatic logic [32:0] clip32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) begin
            return {1'b1, Q_MAX};
        end
        if (x < -72'sd2147483648) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, x[31:0]};
    endfunction

    // x' = alpha * op(T) * x, results go to the expected queue and back into the vector
    task automatic compute_trmv();
        int                 n;
        int                 i;
        int                 j;
        int                 r;
        int                 c;
        logic signed [71:0] acc;
        logic signed [63:0] term;
        logic signed [31:0] t_val;
        logic signed [31:0] s;
        logic               hit_sum;
        logic               hit_scale;
        logic signed [31:0] res [0:MAX_N-1];
        logic               clip [0:MAX_N-1];
        n = (cfg_size > MAX_N) ? MAX_N : int'(cfg_size);
        for (i = 0; i < n; i++) begin
            acc = '0;
            for (j = 0; j < n; j++) begin
                r = cfg_trans ? j : i;
                c = cfg_trans ? i : j;
                if (cfg_upper ? (r <= c) : (r >= c)) begin
                    t_val = (r == c && cfg_unit) ? Q_ONE : mat_mem[r][c];
                end else begin
                    t_val = '0;
                end
                term = t_val * vec_mem[j];
                acc  = acc + term;
            end
            {hit_sum, s} = clip32(acc >>> 16);
            term = s * cfg_scale;
            {hit_scale, res[i]} = clip32(term >>> 16);
            clip[i] = hit_sum | hit_scale;
        end
        for (i = 0; i < n; i++) begin
            vec_mem[i] = res[i];
            product_elems.push_back('{index: 4'(i), result: res[i], saturated: clip[i],
                                      last: (i == n - 1)});
        end
    endtask

    // monitor: watchdog, result check, config and request capture
    always @(posedge i_clk) begin : monitor
        t_product_elem want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no activity for %0d cycles", quiet_cycles);
            $display("tb_triangular_matrix_vector_multiply failed");
            $finish;
        end else begin
            quiet_cycles++;
            // result check against the oldest expectation
            if (o_strobe === 1'b1) begin
                quiet_cycles = 0;
                if (product_elems.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result index %0d value %0d",
                                            o_index, o_result));
                end else begin
                    want = product_elems.pop_front();
                    if (o_index !== want.index)
                        flag_mismatch($sformatf("index %0d, expected %0d",
                                                o_index, want.index));
                    if (o_result !== want.result)
                        flag_mismatch($sformatf("element %0d result %0d, expected %0d",
                                                want.index, o_result, want.result));
                    if (o_saturated !== want.saturated)
                        flag_mismatch($sformatf("element %0d saturated %b, expected %b",
                                                want.index, o_saturated, want.saturated));
                    if (o_last !== want.last)
                        flag_mismatch($sformatf("element %0d last %b, expected %b",
                                                want.index, o_last, want.last));
                end
            end
            // register write
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                quiet_cycles = 0;
                case (i_cfg_index)
                    CFG_UPPER:     cfg_upper = i_cfg_data[0];
                    CFG_TRANSPOSE: cfg_trans = i_cfg_data[0];
                    CFG_UNIT_DIAG: cfg_unit  = i_cfg_data[0];
                    CFG_SCALE:     cfg_scale = i_cfg_data;
                    CFG_SIZE:      cfg_size  = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // request taken
            if (start && busy === 1'b0) begin
                quiet_cycles = 0;
                req_taken    = 1'b1;
                void'(requests.pop_front());
                case (i_func)
                    FUNC_MAT: mat_mem[i_row][i_col] = i_value;
                    FUNC_VEC: vec_mem[i_row] = i_value;
                    FUNC_RUN: compute_trmv();
                    default: ;
                endcase
            end
        end
    end

    // driver: presents queued requests with random idle bursts
    always @(negedge i_clk) begin : driver
        if (req_taken) begin
            req_taken  = 1'b0;
            presenting = 1'b0;
            if (!calm && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 6);
            end
        end
        if (!presenting) begin
            if (gap > 0) begin
                gap--;
                start <= 1'b0;
            end else if (requests.size() > 0) begin
                i_func     <= requests[0].func;
                i_row      <= requests[0].row;
                i_col      <= requests[0].col;
                i_value    <= requests[0].value;
                start      <= 1'b1;
                presenting = 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // random Q16.16 value, mostly small, sometimes extreme
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 11))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'sd0;
            3, 4:    return $urandom;
            default: return int'($urandom_range(0, 524288)) - 262144;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'sd0;
            3, 4:    return Q_ONE;
            5:       return -Q_ONE;
            default: return int'($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    // index mostly inside the active order
    function automatic logic [3:0] pick_index();
        if (gen_n > 0 && $urandom_range(0, 3) != 0) begin
            return 4'($urandom_range(0, gen_n - 1));
        end
        return 4'($urandom);
    endfunction

    task automatic push_req(input logic [1:0] func, input logic [3:0] row,
                            input logic [3:0] col, input logic signed [31:0] value);
        int j;
        requests.push_back('{func: func, row: row, col: col, value: value});
        case (func)
            FUNC_MAT: mat_set[row][col] = 1'b1;
            FUNC_VEC: vec_set[row] = 1'b1;
            FUNC_RUN: for (j = 0; j < gen_n; j++) vec_set[j] = 1'b1;
            default: ;
        endcase
        if (func != FUNC_SPARE) begin
            stim_items++;
        end
    endtask

    // load whatever the run will read that has not been written, then run
    task automatic issue_run();
        int r;
        int c;
        for (r = 0; r < gen_n; r++) begin
            if (!vec_set[r]) push_req(FUNC_VEC, 4'(r), 4'($urandom), rand_q());
        end
        for (r = 0; r < gen_n; r++) begin
            for (c = 0; c < gen_n; c++) begin
                if ((gen_upper ? (r <= c) : (r >= c)) && !mat_set[r][c]) begin
                    push_req(FUNC_MAT, 4'(r), 4'(c), rand_q());
                end
            end
        end
        push_req(FUNC_RUN, 4'($urandom), 4'($urandom), $urandom);
    endtask

    // wait until all requests are taken and all results seen, then let the block settle
    task automatic drain();
        while (requests.size() != 0 || product_elems.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
    endtask

    // write every register, plus one write to an unused index
    task automatic set_mode(input bit up, input bit tr, input bit ud,
                            input logic signed [31:0] alpha, input logic [4:0] order);
        drain();
        cfg_write(CFG_UPPER,     ($urandom & ~32'h1) | 32'(up));
        cfg_write(CFG_TRANSPOSE, ($urandom & ~32'h1) | 32'(tr));
        cfg_write(CFG_UNIT_DIAG, ($urandom & ~32'h1) | 32'(ud));
        cfg_write(CFG_SCALE,     alpha);
        cfg_write(CFG_SIZE,      ($urandom & ~32'h1f) | 32'(order));
        cfg_write(CFG_SPARE_LO + CFG_IW'($urandom_range(0, 2)), $urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        gen_upper = up;
        gen_n     = (order > MAX_N) ? MAX_N : int'(order);
    endtask

    // stimulus
    initial begin : stimulus
        int base;
        int k;
        int sz;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lower triangle, order two: both saturation points, max indexes, unused func
        set_mode(1'b0, 1'b0, 1'b0, Q_ONE, 5'd2);
        push_req(FUNC_MAT, 4'd0, 4'd0, Q_MAX);
        push_req(FUNC_MAT, 4'd1, 4'd0, Q_MIN);
        push_req(FUNC_MAT, 4'd1, 4'd1, Q_ONE);
        push_req(FUNC_MAT, 4'd15, 4'd15, 32'sd0);
        push_req(FUNC_MAT, 4'd0, 4'd15, Q_MIN);
        push_req(FUNC_VEC, 4'd0, 4'd15, Q_MAX);
        push_req(FUNC_VEC, 4'd1, 4'd0, Q_MIN);
        push_req(FUNC_VEC, 4'd15, 4'd15, Q_ONE);
        push_req(FUNC_SPARE, 4'd15, 4'd15, Q_MAX);
        push_req(FUNC_RUN, 4'd0, 4'd0, 32'sd0);
        push_req(FUNC_RUN, 4'd15, 4'd15, Q_MIN);

        // upper, transposed, unit diagonal, most negative alpha
        set_mode(1'b1, 1'b1, 1'b1, Q_MIN, 5'd3);
        issue_run();
        issue_run();

        // order one, largest alpha
        set_mode(1'b0, 1'b1, 1'b0, Q_MAX, 5'd1);
        issue_run();

        // order zero: a run that yields nothing
        set_mode(1'b1, 1'b0, 1'b1, 32'sd0, 5'd0);
        issue_run();

        // order beyond the limit clips to sixteen
        set_mode(1'b0, 1'b0, 1'b1, -Q_ONE, 5'd31);
        issue_run();

        // random phases of well-formed load/run sequences with some noise
        base = stim_items;
        while (stim_items < base + ITEM_COUNT) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                sz = 0;
            end else if (k == 1) begin
                sz = $urandom_range(16, 31);
            end else begin
                sz = $urandom_range(1, 5);
            end
            set_mode(1'($urandom), 1'($urandom), 1'($urandom), rand_scale(), 5'(sz));
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 4)) begin
                    k = $urandom_range(0, 9);
                    if (k == 0) begin
                        push_req(FUNC_SPARE, 4'($urandom), 4'($urandom), $urandom);
                    end else if (k < 5) begin
                        push_req(FUNC_VEC, pick_index(), 4'($urandom), rand_q());
                    end else begin
                        push_req(FUNC_MAT, pick_index(), pick_index(), rand_q());
                    end
                end
                issue_run();
            end
            if (stim_items >= base + ITEM_COUNT - 20) begin
                calm = 1'b1;
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("tb_triangular_matrix_vector_multiply passed");
        end else begin
            $display("tb_triangular_matrix_vector_multiply failed");
        end
        $finish;
    end

endmodule
